FILE: design/atrst_pkg.sv
// Shared types and constants of the ATR and SuperTrend block.
package atrst_pkg;

    localparam int AVG_W       = 48;
    localparam int LINE_W      = 34;
    localparam int BAND_W      = 16;
    localparam int WLEN_W      = 7;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_FACTOR   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SMA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WMA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RMA = 2'd3;

    localparam logic [MODE_W-1:0] RST_MODE = MODE_RMA;
    localparam logic [WLEN_W-1:0] RST_WLEN = 7'd14;
    localparam logic [BAND_W-1:0] RST_BAND = 16'd768;

    typedef struct packed {
        logic load;
        logic store;
        logic sel;
        logic rd;
        logic acc_add;
        logic seed;
        logic num;
        logic div;
        logic quo;
        logic mul;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic              seen;
        logic [MODE_W-1:0] mode;
        logic              e_zero;
        logic              out_free;
    } t_status;

endpackage

FILE: design/atrst_ctrl.sv
// Sequencer that walks the window, runs the divider and finishes each item.
module atrst_ctrl #(
    parameter int WINDOW_DEPTH = 64,
    parameter int NUM_W        = 61
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  atrst_pkg::t_status                  i_status,
    input  logic [$clog2(WINDOW_DEPTH+2)-1:0]   i_fill,
    output logic [$clog2(WINDOW_DEPTH+2)-1:0]   o_k,
    output atrst_pkg::t_cmd                     o_cmd
);

    localparam int FW = $clog2(WINDOW_DEPTH + 2);
    localparam int CW = $clog2(NUM_W + 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_TR   = 11'b000_0000_0010,
        ST_SEL  = 11'b000_0000_0100,
        ST_RD   = 11'b000_0000_1000,
        ST_ACC  = 11'b000_0001_0000,
        ST_SEED = 11'b000_0010_0000,
        ST_NUM  = 11'b000_0100_0000,
        ST_DIV  = 11'b000_1000_0000,
        ST_QUO  = 11'b001_0000_0000,
        ST_MUL  = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [FW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]   kp1;
    logic            smooth;

    always_comb begin
        kp1     = r_k + FW'(1);
        smooth  = i_status.mode inside {atrst_pkg::MODE_EMA, atrst_pkg::MODE_RMA};
        n_state = r_state;
        n_k     = r_k;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.seen ? ST_TR : ST_MUL;
                end
            end
            ST_TR: begin
                o_cmd.store = 1'b1;
                n_state     = ST_SEL;
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                n_k       = (smooth && !i_status.e_zero) ? i_fill - FW'(1) : '0;
                n_state   = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                if (!smooth) begin
                    n_state = ST_ACC;
                end else if (i_status.e_zero && r_k == '0) begin
                    n_state = ST_SEED;
                end else begin
                    n_state = ST_NUM;
                end
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (kp1 == i_fill) begin
                    n_state = ST_NUM;
                end else begin
                    n_k     = kp1;
                    n_state = ST_RD;
                end
            end
            ST_SEED: begin
                o_cmd.seed = 1'b1;
                if (kp1 < i_fill) begin
                    n_k     = kp1;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_cnt     = CW'(NUM_W);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = ST_QUO;
                end
            end
            ST_QUO: begin
                o_cmd.quo = 1'b1;
                if (kp1 < i_fill) begin
                    n_k     = kp1;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_k        = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: design/atrst_datapath.sv
// Window store, averaging, serial divider and band logic of the ATR block.
module atrst_datapath #(
    parameter int WINDOW_DEPTH  = 64,
    parameter int PRICE_BITS    = 32,
    parameter int FRACTION_BITS = 16,
    parameter int NUM_W         = 61
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  atrst_pkg::t_cmd                         i_cmd,
    input  logic [$clog2(WINDOW_DEPTH+2)-1:0]       i_k,
    input  logic [PRICE_BITS-1:0]                   i_high,
    input  logic [PRICE_BITS-1:0]                   i_low,
    input  logic [PRICE_BITS-1:0]                   i_close,
    input  logic                                    i_cfg_we,
    input  logic [atrst_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [atrst_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output atrst_pkg::t_status                      o_status,
    output logic [$clog2(WINDOW_DEPTH+2)-1:0]       o_fill,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [atrst_pkg::AVG_W-1:0]             o_range_average,
    output logic                                    o_average_valid,
    output logic [atrst_pkg::LINE_W-1:0]            o_trend_line,
    output logic                                    o_trend_up
);

    localparam int AVG_W  = atrst_pkg::AVG_W;
    localparam int LINE_W = atrst_pkg::LINE_W;
    localparam int BAND_W = atrst_pkg::BAND_W;
    localparam int IW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW     = $clog2(WINDOW_DEPTH + 2);
    localparam int AS_W   = FW + 1;
    localparam int WMAX   = WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2;
    localparam int DW     = $clog2(WMAX + WINDOW_DEPTH + 2);
    localparam int SUM_W  = PRICE_BITS + DW;
    localparam int S      = 8 + FRACTION_BITS;
    localparam int PH_W   = BAND_W + AVG_W - S;
    localparam int PL_W   = BAND_W + S;
    localparam int PINT_W = PH_W + 1;
    localparam int BW0    = (PINT_W > PRICE_BITS + 1) ? PINT_W : PRICE_BITS + 1;
    localparam int BW     = ((BW0 > LINE_W) ? BW0 : LINE_W) + 3;

    localparam logic signed [BW-1:0] LMAX = {{(BW-LINE_W+1){1'b0}}, {(LINE_W-1){1'b1}}};
    localparam logic signed [BW-1:0] LMIN = {{(BW-LINE_W+1){1'b1}}, {(LINE_W-1){1'b0}}};

    // configuration
    logic [atrst_pkg::MODE_W-1:0] r_mode;
    logic [atrst_pkg::WLEN_W-1:0] r_wlen;
    logic [BAND_W-1:0]            r_bf;

    // item and history
    logic [PRICE_BITS-1:0] r_hi, r_lo, r_cl, r_pc;
    logic                  r_seen;
    logic [PRICE_BITS-1:0] r_mem [WINDOW_DEPTH];
    logic [PRICE_BITS-1:0] r_rdata;
    logic [FW-1:0]         r_fill, n_fill;
    logic [IW-1:0]         r_oldest, n_oldest;

    // averaging and divider
    logic [SUM_W-1:0]  r_acc;
    logic [AVG_W-1:0]  r_e, r_atr;
    logic [DW-1:0]     r_rem, r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [PH_W-1:0]   r_ph;
    logic [PL_W-1:0]   r_pl;

    // bands and result
    logic signed [LINE_W-1:0] r_uk, r_lk, r_lnk;
    logic                     r_ovalid;
    logic [AVG_W-1:0]         r_oavg;
    logic                     r_oaval;
    logic [LINE_W-1:0]        r_oline;
    logic                     r_oup;

    // window indexing
    logic [8:0]            wl_ext;
    logic [FW-1:0]         len_eff, fill1, drop;
    logic [AS_W-1:0]       wr_sum, rd_sum, ds_sum;
    logic [IW-1:0]         wr_addr, rd_addr;
    logic [PRICE_BITS-1:0] t0, t1, t2, tr_val;

    always_comb begin
        wl_ext = 9'(r_wlen);
        if (r_wlen == '0) begin
            len_eff = FW'(1);
        end else if (wl_ext > 9'(WINDOW_DEPTH)) begin
            len_eff = FW'(WINDOW_DEPTH);
        end else begin
            len_eff = FW'(r_wlen);
        end
        wr_sum  = AS_W'(r_oldest) + AS_W'(r_fill);
        wr_addr = IW'((wr_sum >= AS_W'(WINDOW_DEPTH)) ? wr_sum - AS_W'(WINDOW_DEPTH) : wr_sum);
        rd_sum  = AS_W'(r_oldest) + AS_W'(i_k);
        rd_addr = IW'((rd_sum >= AS_W'(WINDOW_DEPTH)) ? rd_sum - AS_W'(WINDOW_DEPTH) : rd_sum);
        fill1   = r_fill + FW'(1);
        drop    = fill1 - len_eff;
        ds_sum  = AS_W'(r_oldest) + AS_W'(drop);
        if (fill1 > len_eff) begin
            n_fill   = len_eff;
            n_oldest = IW'((ds_sum >= AS_W'(WINDOW_DEPTH)) ?
                           ds_sum - AS_W'(WINDOW_DEPTH) : ds_sum);
        end else begin
            n_fill   = fill1;
            n_oldest = r_oldest;
        end
        t0     = (r_hi >= r_lo) ? r_hi - r_lo : '0;
        t1     = (r_hi >= r_pc) ? r_hi - r_pc : r_pc - r_hi;
        t2     = (r_lo >= r_pc) ? r_lo - r_pc : r_pc - r_lo;
        tr_val = t0;
        if (t1 > tr_val) tr_val = t1;
        if (t2 > tr_val) tr_val = t2;
    end

    // numerator and divisor of one averaging division
    logic [FW-1:0]              kp1, nm1;
    logic [PRICE_BITS+FW-1:0]   wprod;
    logic [2*FW-1:0]            nn1;
    logic [DW-1:0]              wden;
    logic [AVG_W+FW-1:0]        e_mul;
    logic [NUM_W-1:0]           acc_sh, x_sh, half_n, num;
    logic [DW-1:0]              den;

    always_comb begin
        kp1    = i_k + FW'(1);
        nm1    = r_fill - FW'(1);
        wprod  = {{FW{1'b0}}, r_rdata} * {{PRICE_BITS{1'b0}}, kp1};
        nn1    = {{FW{1'b0}}, r_fill} * {{FW{1'b0}}, fill1};
        wden   = DW'(nn1 >> 1);
        e_mul  = {{FW{1'b0}}, r_e} * {{AVG_W{1'b0}}, nm1};
        acc_sh = NUM_W'(r_acc) << FRACTION_BITS;
        x_sh   = NUM_W'(r_rdata) << FRACTION_BITS;
        half_n = NUM_W'(r_fill >> 1);
        case (r_mode)
            atrst_pkg::MODE_SMA: begin
                num = acc_sh + half_n;
                den = DW'(r_fill);
            end
            atrst_pkg::MODE_WMA: begin
                num = acc_sh + NUM_W'(wden >> 1);
                den = wden;
            end
            atrst_pkg::MODE_EMA: begin
                num = NUM_W'(e_mul) + (x_sh << 1) + NUM_W'(fill1 >> 1);
                den = DW'(fill1);
            end
            default: begin
                num = NUM_W'(e_mul) + x_sh + half_n;
                den = DW'(r_fill);
            end
        endcase
    end

    // restoring divider step
    logic [DW:0] rem_sh, rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // bands
    logic [PINT_W-1:0]        pint;
    logic [S-1:0]             pfrac;
    logic [PRICE_BITS:0]      hsum;
    logic [PRICE_BITS-1:0]    whole;
    logic [S:0]               fu, g, halfv;
    logic signed [BW-1:0]     up_raw, lo_raw, up_sat, lo_sat;
    logic                     lo_rnd;
    logic signed [BW-1:0]     uk_x, lk_x, pc_x, cl_x, up_f, lo_f, line_v;
    logic                     up_flag;

    always_comb begin
        pint   = PINT_W'(r_ph) + PINT_W'(r_pl >> S);
        pfrac  = r_pl[S-1:0];
        hsum   = {1'b0, r_hi} + {1'b0, r_lo};
        whole  = hsum[PRICE_BITS:1];
        halfv  = (S+1)'(hsum[0]) << (S - 1);
        fu     = halfv + {1'b0, pfrac};
        up_raw = $signed(BW'(whole) + BW'(pint) + BW'(fu[S]) + BW'(fu[S-1]));
        g      = halfv - {1'b0, pfrac};
        lo_raw = $signed(BW'(whole) - BW'(pint) - BW'(g[S]));
        if (lo_raw[BW-1]) begin
            lo_rnd = g[S-1] && (|g[S-2:0]);
        end else begin
            lo_rnd = g[S-1];
        end
        lo_raw = lo_raw + $signed(BW'(lo_rnd));
        up_sat = (up_raw > LMAX) ? LMAX : ((up_raw < LMIN) ? LMIN : up_raw);
        lo_sat = (lo_raw > LMAX) ? LMAX : ((lo_raw < LMIN) ? LMIN : lo_raw);
        uk_x   = BW'(r_uk);
        lk_x   = BW'(r_lk);
        pc_x   = $signed(BW'(r_pc));
        cl_x   = $signed(BW'(r_cl));
        up_f   = (up_sat < uk_x || pc_x > uk_x) ? up_sat : uk_x;
        lo_f   = (lo_sat > lk_x || pc_x < lk_x) ? lo_sat : lk_x;
        up_flag = (r_lnk == r_uk) ? (cl_x > up_f) : (cl_x > lo_f);
        line_v = up_flag ? lo_f : up_f;
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[wr_addr] <= tr_val;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= atrst_pkg::RST_MODE;
            r_wlen   <= atrst_pkg::RST_WLEN;
            r_bf     <= atrst_pkg::RST_BAND;
            r_fill   <= '0;
            r_oldest <= '0;
            r_seen   <= 1'b0;
            r_pc     <= '0;
            r_e      <= '0;
            r_uk     <= '0;
            r_lk     <= '0;
            r_lnk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    atrst_pkg::REG_AVERAGE_MODE:  r_mode <= i_cfg_data[atrst_pkg::MODE_W-1:0];
                    atrst_pkg::REG_WINDOW_LENGTH: r_wlen <= i_cfg_data[atrst_pkg::WLEN_W-1:0];
                    atrst_pkg::REG_BAND_FACTOR:   r_bf   <= i_cfg_data[BAND_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                r_fill   <= n_fill;
                r_oldest <= n_oldest;
            end
            if (i_cmd.seed) begin
                r_e <= AVG_W'({r_rdata, {FRACTION_BITS{1'b0}}});
            end
            if (i_cmd.quo && r_mode inside {atrst_pkg::MODE_EMA, atrst_pkg::MODE_RMA}) begin
                r_e <= r_quo[AVG_W-1:0];
            end
            if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_uk     <= up_f[LINE_W-1:0];
                r_lk     <= lo_f[LINE_W-1:0];
                r_lnk    <= line_v[LINE_W-1:0];
                r_pc     <= r_cl;
                r_seen   <= 1'b1;
                r_ovalid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi  <= i_high;
            r_lo  <= i_low;
            r_cl  <= i_close;
            r_atr <= '0;
        end
        if (i_cmd.sel) begin
            r_acc <= '0;
        end
        if (i_cmd.acc_add) begin
            if (r_mode == atrst_pkg::MODE_SMA) begin
                r_acc <= r_acc + SUM_W'(r_rdata);
            end else begin
                r_acc <= r_acc + SUM_W'(wprod);
            end
        end
        if (i_cmd.seed) begin
            r_atr <= AVG_W'({r_rdata, {FRACTION_BITS{1'b0}}});
        end
        if (i_cmd.num) begin
            r_quo <= num;
            r_den <= den;
            r_rem <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
        if (i_cmd.quo) begin
            r_atr <= r_quo[AVG_W-1:0];
        end
        if (i_cmd.mul) begin
            r_ph <= {{BAND_W{1'b0}}, r_atr[AVG_W-1:S]} * {{(AVG_W-S){1'b0}}, r_bf};
            r_pl <= {{BAND_W{1'b0}}, r_atr[S-1:0]} * {{S{1'b0}}, r_bf};
        end
        if (i_cmd.fin) begin
            r_oavg  <= r_atr;
            r_oaval <= r_seen;
            r_oline <= line_v[LINE_W-1:0];
            r_oup   <= up_flag;
        end
    end

    assign o_status.seen     = r_seen;
    assign o_status.mode     = r_mode;
    assign o_status.e_zero   = (r_e == '0);
    assign o_status.out_free = !r_ovalid || i_out_ready;
    assign o_fill            = r_fill;
    assign o_out_valid       = r_ovalid;
    assign o_range_average   = r_oavg;
    assign o_average_valid   = r_oaval;
    assign o_trend_line      = r_oline;
    assign o_trend_up        = r_oup;

endmodule

FILE: design/atr_supertrend_indicator.sv
// Average true range with SuperTrend bands, top level.
// Per item, n = window fill, D = divider steps, one bit per cycle (61 by default):
//   first bar skips the average; SMA/WMA sum n entries, then one division of D steps;
//   EMA/RMA single step is one division; reseed walk does one per entry after the first.
// One item at a time; the next item is taken once the previous result is registered.
// Synchronous active-low reset restores the register defaults and clears the window.
module atr_supertrend_indicator #(
    parameter int WINDOW_DEPTH  = 64,
    parameter int PRICE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // price_high, price_low, price_close
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // range_average, trend_line
    output logic [atrst_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // average_valid, trend_up
    output logic [atrst_pkg::OUT_TUSER_W-1:0]      o_m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [atrst_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [atrst_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AVG_W  = atrst_pkg::AVG_W;
    localparam int LINE_W = atrst_pkg::LINE_W;
    localparam int FW     = $clog2(WINDOW_DEPTH + 2);
    localparam int WMAX   = WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2;
    localparam int DW     = $clog2(WMAX + WINDOW_DEPTH + 2);
    localparam int NA     = PRICE_BITS + DW + FRACTION_BITS;
    localparam int NB     = AVG_W + FW + 1;
    localparam int NC     = PRICE_BITS + FRACTION_BITS + 2;
    localparam int NAB    = (NA > NB) ? NA : NB;
    localparam int NUM_W  = ((NAB > NC) ? NAB : NC) + 1;
    localparam int PAD_W  = atrst_pkg::OUT_TDATA_W - AVG_W - LINE_W;

    atrst_pkg::t_cmd    cmd;
    atrst_pkg::t_status status;
    logic [FW-1:0]      fill, k;
    logic [AVG_W-1:0]   range_average;
    logic [LINE_W-1:0]  trend_line;
    logic               average_valid, trend_up;

    atrst_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .NUM_W        (NUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .i_fill     (fill),
        .o_k        (k),
        .o_cmd      (cmd)
    );

    atrst_datapath #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .NUM_W         (NUM_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_k             (k),
        .i_high          (i_s_axis_tdata[PRICE_BITS-1:0]),
        .i_low           (i_s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
        .i_close         (i_s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (status),
        .o_fill          (fill),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_range_average (range_average),
        .o_average_valid (average_valid),
        .o_trend_line    (trend_line),
        .o_trend_up      (trend_up)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, trend_line, range_average};
    assign o_m_axis_tuser = {trend_up, average_valid};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while previous item still in progress");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= FW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_first_bar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[AVG_W-1:0] == '0))
        else $error("nonzero average without previous bar");

endmodule
